FILE: rtl/core/futex_wait_queue_table_assert.svh
// assertion macros for the wait queue table
`ifndef FUTEX_WAIT_QUEUE_TABLE_ASSERT_SVH
`define FUTEX_WAIT_QUEUE_TABLE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define FWQT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the cycle after the antecedent
`define FWQT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/fwqt_pkg.sv
// ----------------------------------------------------------------------------
// fwqt_pkg
// Shared codes and types of the futex wait queue table.
// ----------------------------------------------------------------------------
package fwqt_pkg;

  localparam logic [2:0] STATUS_QUEUED     = 3'd0;
  localparam logic [2:0] STATUS_WOKE       = 3'd1;
  localparam logic [2:0] STATUS_NOT_FOUND  = 3'd2;
  localparam logic [2:0] STATUS_TABLE_FULL = 3'd3;
  localparam logic [2:0] STATUS_QUEUE_FULL = 3'd4;

  localparam logic CMD_WAIT = 1'b0;
  localparam logic CMD_WAKE = 1'b1;

  localparam logic [31:0] HASH_MULT  = 32'd2654435761;
  localparam int          FOLD_SHIFT = 32;
  localparam logic [4:0]  PAGE_SHIFT_RESET = 5'd12;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HASH,
    ST_HSET,
    ST_PROBE,
    ST_CMP,
    ST_CREATE,
    ST_APPEND,
    ST_WK_SET,
    ST_WK_RD,
    ST_WK_OUT,
    ST_WK_END,
    ST_SH_CHK,
    ST_SH_LOAD,
    ST_SH_HASH,
    ST_SH_HSET,
    ST_SH_FREE,
    ST_SH_PLACE,
    ST_SH_COPY,
    ST_RESP
  } state_t;

endpackage

FILE: rtl/core/futex_wait_queue_table.sv
// ----------------------------------------------------------------------------
// futex_wait_queue_table
// Hash table of wait addresses, each slot holding a fifo of waiting threads.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) takes one command: wait or wake.
//   output channel (out_valid/out_ready) returns one transaction per result:
//   one for wait, failed lookups and wakes that free none, else one per freed thread.
//   config channel (cfg_valid/cfg_ready) writes page_shift, always ready.
// sequencing
//   one command at a time; the key is hashed, then each probed slot is read
//   from the slot memory and compared; a wait then creates or appends.
//   a wake reads the waiter memory once per released thread.
//   when a queue empties, each later entry of the cluster is rehashed and
//   probed for a free slot, and its waiter entries are copied when it moves.
// reset
//   all slots invalid, page_shift 12; no clearing pass, in_ready high once
//   reset has put the state machine in idle.
// stall
//   a finished result waits in the output register; the block stalls
//   until it is taken, and accepts a new command while the last result
//   of the previous one still waits.
module futex_wait_queue_table #(
  parameter int INDEX_BITS     = 6,
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [63:0] wait_address,
  input  logic [7:0]  thread_id,
  input  logic [15:0] wake_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        woken_valid,
  output logic [7:0]  woken_thread,
  output logic [4:0]  woken_total,
  output logic        last
);

  localparam int SIZE = 1 << INDEX_BITS;
  localparam int IB   = INDEX_BITS;
  localparam int CB   = INDEX_BITS + 1;
  localparam int HB   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LB   = $clog2(QUEUE_DEPTH + 1);
  localparam int PW   = LB + 1;
  localparam int TB   = THREAD_ID_BITS;
  localparam int AW   = $clog2(SIZE * QUEUE_DEPTH);
  localparam int SW   = 64 + HB + LB;

  fwqt_pkg::state_t state, state_next;

  logic [4:0]    page_shift;
  logic          cmd;
  logic [63:0]   key;
  logic [TB-1:0] tid;
  logic [15:0]   cnt;
  logic [31:0]   prod;
  logic [IB-1:0] idx;
  logic [CB-1:0] probe_n;
  logic [HB-1:0] hit_head;
  logic [LB-1:0] hit_len;
  logic [LB-1:0] wk_n;
  logic [LB-1:0] wk_i;
  logic [2:0]    res_status;
  logic [CB-1:0] key_total;
  logic [IB-1:0] sh_j;
  logic [CB-1:0] sh_m;
  logic [63:0]   mv_key;
  logic [HB-1:0] mv_head;
  logic [LB-1:0] mv_len;
  logic [IB-1:0] fr_p;
  logic [CB-1:0] fr_c;
  logic [IB-1:0] dst;
  logic [LB-1:0] cp_k;
  logic [SIZE-1:0] slot_valid;

  // slot memory: key, head, length
  logic [SW-1:0] slot_mem [SIZE];
  logic [SW-1:0] slot_rd;
  logic [IB-1:0] sl_raddr;
  logic          sl_we;
  logic [IB-1:0] sl_waddr;
  logic [SW-1:0] sl_wdata;

  // waiter memory: QUEUE_DEPTH entries per slot
  logic [TB-1:0] waiter_mem [SIZE * QUEUE_DEPTH];
  logic [TB-1:0] wq_rd;
  logic [AW-1:0] wq_raddr;
  logic          wq_we;
  logic [AW-1:0] wq_waddr;
  logic [TB-1:0] wq_wdata;

  logic [63:0] rd_key;
  logic [HB-1:0] rd_head;
  logic [LB-1:0] rd_len;
  assign rd_key  = slot_rd[SW-1 -: 64];
  assign rd_head = slot_rd[LB +: HB];
  assign rd_len  = slot_rd[LB-1:0];

  function automatic logic [AW-1:0] wq_addr(input logic [IB-1:0] s, input logic [HB-1:0] p);
    wq_addr = AW'(s) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  // hash unit, shared by lookup and reinsertion
  logic [63:0] hash_src, shifted, folded;
  logic [31:0] prod_c;
  assign hash_src = (state == fwqt_pkg::ST_SH_HASH) ? mv_key : key;
  assign shifted  = hash_src >> page_shift;
  assign folded   = shifted ^ (shifted >> fwqt_pkg::FOLD_SHIFT);
  assign prod_c   = folded[31:0] * fwqt_pkg::HASH_MULT;

  // derived values
  logic [PW-1:0] pos_sum, pos_wrap;
  logic [HB-1:0] head_inc;
  logic [LB-1:0] wake_n;
  logic          out_free;
  assign pos_sum  = PW'(hit_head) + PW'(hit_len);
  assign pos_wrap = (pos_sum >= PW'(QUEUE_DEPTH)) ? pos_sum - PW'(QUEUE_DEPTH) : pos_sum;
  assign head_inc = (hit_head == HB'(QUEUE_DEPTH - 1)) ? '0 : hit_head + 1'b1;
  assign wake_n   = (cnt < 16'(hit_len)) ? LB'(cnt) : hit_len;
  assign out_free = !out_valid || out_ready;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == fwqt_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwqt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sl_raddr   = idx;
    sl_we      = 1'b0;
    sl_waddr   = idx;
    sl_wdata   = {key, hit_head, hit_len};
    wq_raddr   = wq_addr(idx, hit_head);
    wq_we      = 1'b0;
    wq_waddr   = wq_addr(idx, HB'(pos_wrap));
    wq_wdata   = tid;
    unique case (state)
      fwqt_pkg::ST_IDLE: begin
        if (in_valid) state_next = fwqt_pkg::ST_HASH;
      end
      fwqt_pkg::ST_HASH: state_next = fwqt_pkg::ST_HSET;
      fwqt_pkg::ST_HSET: state_next = fwqt_pkg::ST_PROBE;
      fwqt_pkg::ST_PROBE: begin
        if (probe_n == CB'(SIZE)) begin
          state_next = fwqt_pkg::ST_RESP;
        end else if (!slot_valid[idx]) begin
          state_next = (cmd == fwqt_pkg::CMD_WAIT) ? fwqt_pkg::ST_CREATE : fwqt_pkg::ST_RESP;
        end else begin
          state_next = fwqt_pkg::ST_CMP;
        end
      end
      fwqt_pkg::ST_CMP: begin
        if (rd_key == key) begin
          state_next = (cmd == fwqt_pkg::CMD_WAIT) ? fwqt_pkg::ST_APPEND : fwqt_pkg::ST_WK_SET;
        end else begin
          state_next = fwqt_pkg::ST_PROBE;
        end
      end
      fwqt_pkg::ST_CREATE: begin
        sl_we      = 1'b1;
        sl_wdata   = {key, HB'(0), LB'(1)};
        wq_we      = 1'b1;
        wq_waddr   = wq_addr(idx, '0);
        state_next = fwqt_pkg::ST_RESP;
      end
      fwqt_pkg::ST_APPEND: begin
        if (hit_len < LB'(QUEUE_DEPTH)) begin
          sl_we    = 1'b1;
          sl_wdata = {key, hit_head, hit_len + 1'b1};
          wq_we    = 1'b1;
        end
        state_next = fwqt_pkg::ST_RESP;
      end
      fwqt_pkg::ST_WK_SET: begin
        state_next = (wake_n == '0) ? fwqt_pkg::ST_RESP : fwqt_pkg::ST_WK_RD;
      end
      fwqt_pkg::ST_WK_RD: state_next = fwqt_pkg::ST_WK_OUT;
      fwqt_pkg::ST_WK_OUT: begin
        if (out_free) begin
          state_next = (wk_i + 1'b1 == wk_n) ? fwqt_pkg::ST_WK_END : fwqt_pkg::ST_WK_RD;
        end
      end
      fwqt_pkg::ST_WK_END: begin
        sl_we      = 1'b1;
        state_next = (hit_len == '0) ? fwqt_pkg::ST_SH_CHK : fwqt_pkg::ST_IDLE;
      end
      fwqt_pkg::ST_SH_CHK: begin
        sl_raddr = sh_j;
        if (sh_m == CB'(SIZE) || !slot_valid[sh_j]) begin
          state_next = fwqt_pkg::ST_IDLE;
        end else begin
          state_next = fwqt_pkg::ST_SH_LOAD;
        end
      end
      fwqt_pkg::ST_SH_LOAD:  state_next = fwqt_pkg::ST_SH_HASH;
      fwqt_pkg::ST_SH_HASH:  state_next = fwqt_pkg::ST_SH_HSET;
      fwqt_pkg::ST_SH_HSET:  state_next = fwqt_pkg::ST_SH_FREE;
      fwqt_pkg::ST_SH_FREE: begin
        if (fr_c == CB'(SIZE) || !slot_valid[fr_p]) state_next = fwqt_pkg::ST_SH_PLACE;
      end
      fwqt_pkg::ST_SH_PLACE: begin
        if (dst == sh_j) begin
          state_next = fwqt_pkg::ST_SH_CHK;
        end else begin
          sl_we      = 1'b1;
          sl_waddr   = dst;
          sl_wdata   = {mv_key, mv_head, mv_len};
          state_next = fwqt_pkg::ST_SH_COPY;
        end
      end
      fwqt_pkg::ST_SH_COPY: begin
        // read entry k of the source while writing entry k-1 to the destination
        wq_raddr = wq_addr(sh_j, HB'(cp_k));
        wq_we    = (cp_k != '0);
        wq_waddr = wq_addr(dst, HB'(cp_k - 1'b1));
        wq_wdata = wq_rd;
        if (cp_k == LB'(QUEUE_DEPTH)) state_next = fwqt_pkg::ST_SH_CHK;
      end
      fwqt_pkg::ST_RESP: begin
        if (out_free) state_next = fwqt_pkg::ST_IDLE;
      end
      default: state_next = fwqt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_rd <= slot_mem[sl_raddr];
    if (sl_we) slot_mem[sl_waddr] <= sl_wdata;
  end

  always_ff @(posedge clk) begin
    wq_rd <= waiter_mem[wq_raddr];
    if (wq_we) waiter_mem[wq_waddr] <= wq_wdata;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= fwqt_pkg::PAGE_SHIFT_RESET;
      slot_valid <= '0;
      key_total  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) page_shift <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        fwqt_pkg::ST_CREATE: begin
          slot_valid[idx] <= 1'b1;
          key_total       <= key_total + 1'b1;
        end
        fwqt_pkg::ST_WK_OUT: begin
          if (out_free) out_valid <= 1'b1;
        end
        fwqt_pkg::ST_WK_END: begin
          if (hit_len == '0) begin
            slot_valid[idx] <= 1'b0;
            if (key_total != '0) key_total <= key_total - 1'b1;
          end
        end
        fwqt_pkg::ST_SH_LOAD:  slot_valid[sh_j] <= 1'b0;
        fwqt_pkg::ST_SH_PLACE: slot_valid[dst]  <= 1'b1;
        fwqt_pkg::ST_RESP: begin
          if (out_free) out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      fwqt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd <= command;
          key <= wait_address;
          tid <= TB'(thread_id);
          cnt <= wake_count;
        end
      end
      fwqt_pkg::ST_HASH, fwqt_pkg::ST_SH_HASH: prod <= prod_c;
      fwqt_pkg::ST_HSET: begin
        idx     <= prod[IB-1:0];
        probe_n <= '0;
      end
      fwqt_pkg::ST_PROBE: begin
        if (probe_n == CB'(SIZE)) begin
          res_status <= (cmd == fwqt_pkg::CMD_WAIT) ? fwqt_pkg::STATUS_TABLE_FULL
                                                     : fwqt_pkg::STATUS_NOT_FOUND;
        end else if (!slot_valid[idx]) begin
          res_status <= (cmd == fwqt_pkg::CMD_WAIT) ? fwqt_pkg::STATUS_QUEUED
                                                     : fwqt_pkg::STATUS_NOT_FOUND;
        end
      end
      fwqt_pkg::ST_CMP: begin
        hit_head <= rd_head;
        hit_len  <= rd_len;
        if (rd_key != key) begin
          idx     <= idx + 1'b1;
          probe_n <= probe_n + 1'b1;
        end
      end
      fwqt_pkg::ST_APPEND: begin
        res_status <= (hit_len < LB'(QUEUE_DEPTH)) ? fwqt_pkg::STATUS_QUEUED
                                                   : fwqt_pkg::STATUS_QUEUE_FULL;
      end
      fwqt_pkg::ST_WK_SET: begin
        wk_n       <= wake_n;
        wk_i       <= '0;
        res_status <= fwqt_pkg::STATUS_WOKE;
      end
      fwqt_pkg::ST_WK_OUT: begin
        if (out_free) begin
          status       <= fwqt_pkg::STATUS_WOKE;
          woken_valid  <= 1'b1;
          woken_thread <= 8'(wq_rd);
          woken_total  <= 5'(wk_n);
          last         <= (wk_i + 1'b1 == wk_n);
          hit_head     <= head_inc;
          hit_len      <= hit_len - 1'b1;
          wk_i         <= wk_i + 1'b1;
        end
      end
      fwqt_pkg::ST_WK_END: begin
        sh_j <= idx + 1'b1;
        sh_m <= '0;
      end
      fwqt_pkg::ST_SH_LOAD: begin
        mv_key  <= rd_key;
        mv_head <= rd_head;
        mv_len  <= rd_len;
      end
      fwqt_pkg::ST_SH_HSET: begin
        fr_p <= prod[IB-1:0];
        fr_c <= '0;
      end
      fwqt_pkg::ST_SH_FREE: begin
        if (fr_c == CB'(SIZE)) begin
          dst <= sh_j;
        end else if (!slot_valid[fr_p]) begin
          dst <= fr_p;
        end else begin
          fr_p <= fr_p + 1'b1;
          fr_c <= fr_c + 1'b1;
        end
      end
      fwqt_pkg::ST_SH_PLACE: begin
        cp_k <= '0;
        if (dst == sh_j) begin
          sh_j <= sh_j + 1'b1;
          sh_m <= sh_m + 1'b1;
        end
      end
      fwqt_pkg::ST_SH_COPY: begin
        cp_k <= cp_k + 1'b1;
        if (cp_k == LB'(QUEUE_DEPTH)) begin
          sh_j <= sh_j + 1'b1;
          sh_m <= sh_m + 1'b1;
        end
      end
      fwqt_pkg::ST_RESP: begin
        if (out_free) begin
          status       <= res_status;
          woken_valid  <= 1'b0;
          woken_thread <= '0;
          woken_total  <= '0;
          last         <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  `include "futex_wait_queue_table_assert.svh"

  `FWQT_ASSERT_NEXT(a_accept_hash, in_valid && in_ready, state == fwqt_pkg::ST_HASH, "accepted transaction did not start hashing")
  `FWQT_ASSERT_IMP(a_woken_status, out_valid && woken_valid, status == fwqt_pkg::STATUS_WOKE, "woken thread without woke status")
  `FWQT_ASSERT_IMP(a_total_zero, out_valid && status != fwqt_pkg::STATUS_WOKE, woken_total == 5'd0 && last, "non-wake result with count or not last")
  `FWQT_ASSERT_IMP(a_wake_bound, state == fwqt_pkg::ST_WK_OUT, wk_i < wk_n, "wake loop past its count")

endmodule

FILE: dv/futex_wait_queue_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// futex_wait_queue_table_tb
// Self-checking bench: directed and random wait/wake commands, page_shift
// changes between phases, a table-filling phase, and a predictor of the
// hash table and its waiter queues checked against every output transaction.
// ----------------------------------------------------------------------------
module futex_wait_queue_table_tb;
  import fwqt_pkg::*;

  localparam int SLOTS       = 64;
  localparam int QDEPTH      = 16;
  localparam int SETTLE      = 6000;   // worst backward-shift pass, rounded up
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0] status;
    logic       woken_valid;
    logic [7:0] woken_thread;
    logic [4:0] woken_total;
    logic       last;
  } result_t;

  typedef struct {
    logic        cmd;
    logic [63:0] addr;
    logic [7:0]  tid;
    logic [15:0] cnt;
    bit          known;
    logic [2:0]  exp_status;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [63:0] wait_address;
  logic [7:0]  thread_id;
  logic [15:0] wake_count;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic        woken_valid;
  logic [7:0]  woken_thread;
  logic [4:0]  woken_total;
  logic        last;

  // predictor state
  logic [4:0]  shift_m;
  bit          valid_m [SLOTS];
  logic [63:0] key_m   [SLOTS];
  int          head_m  [SLOTS];
  int          len_m   [SLOTS];
  logic [7:0]  waiters_m [SLOTS][QDEPTH];

  result_t     pending_results[$];
  int          errors;
  int          items_sent;
  int          burst_left;
  int          idle_cycles;
  bit          hold_done;
  int          hold_cnt;
  logic [63:0] key_pool[8];

  futex_wait_queue_table i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .wait_address(wait_address), .thread_id(thread_id), .wake_count(wake_count),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .woken_valid(woken_valid), .woken_thread(woken_thread),
    .woken_total(woken_total), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int home_of(logic [63:0] addr);
    logic [63:0] v;
    logic [31:0] h;
    v = addr >> shift_m;
    v = v ^ (v >> FOLD_SHIFT);
    h = v[31:0] * HASH_MULT;
    return int'(h[5:0]);
  endfunction

  // first free slot from the home slot, SLOTS if none
  function automatic int first_free(logic [63:0] addr);
    int idx;
    idx = home_of(addr);
    for (int n = 0; n < SLOTS; n++) begin
      if (!valid_m[idx]) return idx;
      idx = (idx + 1) % SLOTS;
    end
    return SLOTS;
  endfunction

  // the emptied slot is cleared, then the rest of the cluster is reinserted
  function automatic void release_slot(int idx);
    logic [63:0] k;
    int          hd, ln, dst;
    logic [7:0]  buf_q [QDEPTH];
    valid_m[idx] = 0;
    idx = (idx + 1) % SLOTS;
    for (int n = 0; n < SLOTS && valid_m[idx]; n++) begin
      k = key_m[idx];
      hd = head_m[idx];
      ln = len_m[idx];
      buf_q = waiters_m[idx];
      valid_m[idx] = 0;
      dst = first_free(k);
      if (dst >= SLOTS) dst = idx;
      valid_m[dst] = 1;
      key_m[dst] = k;
      head_m[dst] = hd;
      len_m[dst] = ln;
      waiters_m[dst] = buf_q;
      idx = (idx + 1) % SLOTS;
    end
  endfunction

  function automatic result_t make_result(logic [2:0] st, logic wv, logic [7:0] th,
                                          logic [4:0] tot, logic lst);
    result_t r;
    r.status = st;
    r.woken_valid = wv;
    r.woken_thread = th;
    r.woken_total = tot;
    r.last = lst;
    return r;
  endfunction

  // applies one command to the table copy and queues the results it causes
  function automatic logic [2:0] apply_command(logic cmd, logic [63:0] addr,
                                               logic [7:0] tid, logic [15:0] cnt);
    int idx, empty, n, h;
    idx = SLOTS;
    empty = SLOTS;
    h = home_of(addr);
    for (int i = 0; i < SLOTS; i++) begin
      if (!valid_m[h]) begin
        empty = h;
        break;
      end
      if (key_m[h] == addr) begin
        idx = h;
        break;
      end
      h = (h + 1) % SLOTS;
    end
    if (cmd == CMD_WAIT) begin
      if (idx >= SLOTS) begin
        if (empty >= SLOTS) begin
          pending_results.push_back(make_result(STATUS_TABLE_FULL, 0, 0, 0, 1));
          return STATUS_TABLE_FULL;
        end
        idx = empty;
        valid_m[idx] = 1;
        key_m[idx] = addr;
        head_m[idx] = 0;
        len_m[idx] = 0;
      end
      if (len_m[idx] >= QDEPTH) begin
        pending_results.push_back(make_result(STATUS_QUEUE_FULL, 0, 0, 0, 1));
        return STATUS_QUEUE_FULL;
      end
      waiters_m[idx][(head_m[idx] + len_m[idx]) % QDEPTH] = tid;
      len_m[idx]++;
      pending_results.push_back(make_result(STATUS_QUEUED, 0, 0, 0, 1));
      return STATUS_QUEUED;
    end
    if (idx >= SLOTS) begin
      pending_results.push_back(make_result(STATUS_NOT_FOUND, 0, 0, 0, 1));
      return STATUS_NOT_FOUND;
    end
    n = (int'(cnt) > len_m[idx]) ? len_m[idx] : int'(cnt);
    if (n == 0) begin
      pending_results.push_back(make_result(STATUS_WOKE, 0, 0, 0, 1));
      return STATUS_WOKE;
    end
    for (int i = 0; i < n; i++) begin
      pending_results.push_back(make_result(STATUS_WOKE, 1, waiters_m[idx][head_m[idx]],
                                            5'(n), i + 1 == n));
      head_m[idx] = (head_m[idx] + 1) % QDEPTH;
      len_m[idx]--;
    end
    if (len_m[idx] == 0) release_slot(idx);
    return STATUS_WOKE;
  endfunction

  task automatic send_item(logic cmd, logic [63:0] addr, logic [7:0] tid,
                           logic [15:0] cnt, bit known, logic [2:0] exp_st);
    logic [2:0] first_st;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 5);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    wait_address <= addr;
    thread_id    <= tid;
    wake_count   <= cnt;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
    first_st = apply_command(cmd, addr, tid, cnt);
    if (known && first_st !== exp_st) begin
      $error("directed row status: expected %0d, predicted %0d", exp_st, first_st);
      errors++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_shift(logic [4:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shift_m = value;
  endtask

  function automatic logic [63:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] rand_count();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic random_phase(int n_items);
    logic [63:0] base;
    logic [63:0] addr;
    logic        cmd;
    base = rand_addr();
    // half the keys lie close together, so they collide on one home slot unless page_shift is small
    foreach (key_pool[i])
      key_pool[i] = (i < 4) ? base + 64'(8 * i) : rand_addr();
    for (int i = 0; i < n_items; i++) begin
      addr = ($urandom_range(0, 9) == 0) ? rand_addr() : key_pool[$urandom_range(0, 7)];
      cmd = ($urandom_range(0, 9) < 6) ? CMD_WAIT : CMD_WAKE;
      send_item(cmd, addr, 8'($urandom), rand_count(), 0, STATUS_QUEUED);
    end
  endtask

  // every slot taken, then one more key, then every new key woken again
  task automatic fill_phase();
    logic [63:0] keys[SLOTS + 1];
    foreach (keys[i]) keys[i] = rand_addr();
    foreach (keys[i]) send_item(CMD_WAIT, keys[i], 8'($urandom), 16'd0, 0, STATUS_QUEUED);
    foreach (keys[i]) send_item(CMD_WAKE, keys[i], 8'd0, 16'hffff, 0, STATUS_WOKE);
  endtask

  row_t directed[] = '{
    '{CMD_WAKE, 64'h0000_0000_0000_1000, 8'd0,   16'd1,     1, STATUS_NOT_FOUND},
    '{CMD_WAIT, 64'h0,                   8'd0,   16'd0,     1, STATUS_QUEUED},
    '{CMD_WAIT, 64'hffff_ffff_ffff_ffff, 8'd255, 16'hffff,  1, STATUS_QUEUED},
    '{CMD_WAKE, 64'h0,                   8'd0,   16'd0,     1, STATUS_WOKE},
    '{CMD_WAKE, 64'hffff_ffff_ffff_ffff, 8'd0,   16'hffff,  1, STATUS_WOKE},
    '{CMD_WAKE, 64'hffff_ffff_ffff_ffff, 8'd0,   16'd1,     1, STATUS_NOT_FOUND},
    '{CMD_WAIT, 64'h0000_0000_0000_5000, 8'd7,   16'd0,     1, STATUS_QUEUED},
    '{CMD_WAIT, 64'h0000_0000_0000_5000, 8'd7,   16'd0,     1, STATUS_QUEUED},
    '{CMD_WAIT, 64'h0000_0000_0000_5008, 8'd9,   16'd0,     1, STATUS_QUEUED},
    '{CMD_WAIT, 64'h0000_0000_0000_5010, 8'd11,  16'd0,     1, STATUS_QUEUED},
    '{CMD_WAKE, 64'h0000_0000_0000_5000, 8'd0,   16'd2,     0, STATUS_WOKE},
    '{CMD_WAKE, 64'h0000_0000_0000_5010, 8'd0,   16'd3,     0, STATUS_WOKE},
    '{CMD_WAIT, 64'h8000_0000_0000_0000, 8'haa,  16'd0,     0, STATUS_QUEUED},
    '{CMD_WAIT, 64'h8000_0000_0000_0000, 8'h55,  16'd0,     0, STATUS_QUEUED},
    '{CMD_WAKE, 64'h0000_0000_0000_5008, 8'd0,   16'h8000,  0, STATUS_WOKE},
    '{CMD_WAKE, 64'h8000_0000_0000_0000, 8'd0,   16'h7fff,  0, STATUS_WOKE},
    '{CMD_WAIT, 64'h5555_5555_5555_5555, 8'h01,  16'd0,     0, STATUS_QUEUED},
    '{CMD_WAKE, 64'haaaa_aaaa_aaaa_aaaa, 8'h80,  16'd1,     1, STATUS_NOT_FOUND},
    '{CMD_WAKE, 64'h5555_5555_5555_5555, 8'd0,   16'd1,     0, STATUS_WOKE}
  };

  // queue full: one key filled past its depth
  task automatic overflow_queue();
    for (int i = 0; i <= QDEPTH; i++)
      send_item(CMD_WAIT, 64'h0000_0000_0000_9000, 8'(i), 16'd0, i == QDEPTH,
                STATUS_QUEUE_FULL);
    send_item(CMD_WAKE, 64'h0000_0000_0000_9000, 8'd0, 16'hffff, 0, STATUS_WOKE);
  endtask

  // output checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("output transaction with no result expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          errors++;
        end
        if (woken_valid !== want.woken_valid) begin
          $error("woken_valid: expected %0d, actual %0d", want.woken_valid, woken_valid);
          errors++;
        end
        if (woken_thread !== want.woken_thread) begin
          $error("woken_thread: expected %0d, actual %0d", want.woken_thread, woken_thread);
          errors++;
        end
        if (woken_total !== want.woken_total) begin
          $error("woken_total: expected %0d, actual %0d", want.woken_total, woken_total);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, calm stretches, and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && items_sent >= 45) begin
      hold_done <= 1'b1;
      hold_cnt <= 300;
      out_ready <= 1'b0;
    end else if ((items_sent / 16) % 3 == 1) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_WAIT;
    wait_address = '0;
    thread_id = '0;
    wake_count = '0;
    errors = 0;
    items_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    hold_done = 0;
    hold_cnt = 0;
    shift_m = PAGE_SHIFT_RESET;
    foreach (valid_m[i]) begin
      valid_m[i] = 0;
      key_m[i] = '0;
      head_m[i] = 0;
      len_m[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].addr, directed[i].tid, directed[i].cnt,
                directed[i].known, directed[i].exp_status);
    overflow_queue();
    random_phase(40);
    write_shift(5'd0);
    random_phase(25);
    write_shift(5'd20);
    random_phase(20);
    write_shift(5'd31);
    random_phase(15);
    write_shift(5'($urandom_range(1, 19)));
    fill_phase();
    random_phase(15);
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
